### rtl/frs_pkg.sv
// Shared constants and register codes for the frame rotate scatter block.
package frs_pkg;

	// Default largest frame dimension in pixels
	localparam int MAX_DIM = 4096;

	// Field widths
	localparam int PIXEL_W    = 16;
	localparam int IDX_W      = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int ROT_W      = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION = 2'd2;

	// Rotation codes, clockwise
	localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
	localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
	localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
	localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

endpackage

### rtl/frame_rotate_scatter.sv
// Top level: destination index for each pixel of a frame rotated by 0, 90, 180 or 270 degrees.
// Each pixel passes through the queue and then the back-end output register before m_tvalid rises.
// Throughput: one pixel per clock while m_tready stays high, set by the single multiply-add in the back end.
// A two-entry queue lets the input accept two more pixels while the output stalls.
// Reset: width and height 1, rotation 0, row and column counters cleared, queue empty.
// Any write to width, height or rotation restarts the frame at row 0, column 0.
module frame_rotate_scatter #(
	parameter int MAX_DIM = frs_pkg::MAX_DIM
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [frs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [frs_pkg::CFG_DATA_W-1:0] cfg_data,
	// pixel input
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [15:0]                    s_tdata,   // [15:0] pixel_in
	// result output
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [39:0]                    m_tdata,   // [23:0] dest_index, [39:24] pixel_out
	output logic                           m_tlast    // frame_done
);

	localparam int CNT_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int Q_W   = CNT_W + DIM_W + CNT_W + 1 + frs_pkg::PIXEL_W;

	logic                        push;
	logic                        queue_full;
	logic [CNT_W-1:0]            f_a;
	logic [DIM_W-1:0]            f_b;
	logic [CNT_W-1:0]            f_c;
	logic                        f_last;
	logic [Q_W-1:0]              q_in;
	logic [Q_W-1:0]              q_out;
	logic                        q_not_empty;
	logic                        b_ready;
	logic [CNT_W-1:0]            b_a;
	logic [DIM_W-1:0]            b_b;
	logic [CNT_W-1:0]            b_c;
	logic                        b_last;
	logic [frs_pkg::PIXEL_W-1:0] b_pixel;
	logic [frs_pkg::IDX_W-1:0]   dest_index;
	logic [frs_pkg::PIXEL_W-1:0] pixel_out;

	frs_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.push      (push),
		.queue_full(queue_full),
		.op_a      (f_a),
		.op_b      (f_b),
		.op_c      (f_c),
		.op_last   (f_last)
	);

	// Pack classified item with its pixel
	assign q_in = {s_tdata, f_last, f_c, f_b, f_a};

	frs_queue #(
		.WIDTH(Q_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(q_in),
		.full     (queue_full),
		.pop      (q_not_empty & b_ready),
		.not_empty(q_not_empty),
		.pop_data (q_out)
	);

	assign {b_pixel, b_last, b_c, b_b, b_a} = q_out;

	frs_back #(
		.MAX_DIM(MAX_DIM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(q_not_empty),
		.item_ready(b_ready),
		.op_a      (b_a),
		.op_b      (b_b),
		.op_c      (b_c),
		.op_last   (b_last),
		.op_pixel  (b_pixel),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.dest_index(dest_index),
		.pixel_out (pixel_out),
		.frame_done(m_tlast)
	);

	assign m_tdata = {pixel_out, dest_index};

endmodule

### rtl/frs_front.sv
// Front end: configuration registers, raster counters and index operand selection.
module frs_front #(
	parameter int MAX_DIM = frs_pkg::MAX_DIM,
	localparam int CNT_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1,
	localparam int DIM_W = $clog2(MAX_DIM + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [frs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [frs_pkg::CFG_DATA_W-1:0] cfg_data,
	// pixel input
	input  logic                           in_valid,
	output logic                           in_ready,
	// classified item toward the queue
	output logic                           push,
	input  logic                           queue_full,
	output logic [CNT_W-1:0]               op_a,
	output logic [DIM_W-1:0]               op_b,
	output logic [CNT_W-1:0]               op_c,
	output logic                           op_last
);

	logic [frs_pkg::CFG_DATA_W-1:0] width_q;
	logic [frs_pkg::CFG_DATA_W-1:0] height_q;
	logic [frs_pkg::ROT_W-1:0]      rot_q;
	logic [CNT_W-1:0]               row_q;
	logic [CNT_W-1:0]               col_q;
	logic [31:0]                    w_wide;
	logic [31:0]                    h_wide;
	logic [DIM_W-1:0]               eff_w;
	logic [DIM_W-1:0]               eff_h;
	logic [DIM_W-1:0]               w_m1;
	logic [DIM_W-1:0]               h_m1;
	logic [CNT_W-1:0]               h_m1_r;
	logic [CNT_W-1:0]               w_m1_c;
	logic                           col_end;
	logic                           row_end;
	logic                           cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign in_ready  = ~queue_full;
	assign push      = in_valid & in_ready;

	// Clamp dimensions to 1..MAX_DIM
	always_comb begin
		w_wide = 32'(width_q);
		h_wide = 32'(height_q);
		if (w_wide == 32'd0) begin
			w_wide = 32'd1;
		end else if (w_wide > 32'(MAX_DIM)) begin
			w_wide = 32'(MAX_DIM);
		end
		if (h_wide == 32'd0) begin
			h_wide = 32'd1;
		end else if (h_wide > 32'(MAX_DIM)) begin
			h_wide = 32'(MAX_DIM);
		end
	end

	assign eff_w   = w_wide[DIM_W-1:0];
	assign eff_h   = h_wide[DIM_W-1:0];
	assign w_m1    = eff_w - DIM_W'(1);
	assign h_m1    = eff_h - DIM_W'(1);
	assign h_m1_r  = CNT_W'(h_m1 - DIM_W'(row_q));
	assign w_m1_c  = CNT_W'(w_m1 - DIM_W'(col_q));
	assign col_end = (DIM_W'(col_q) == w_m1);
	assign row_end = (DIM_W'(row_q) == h_m1);
	assign op_last = col_end & row_end;

	// Select multiplicand, multiplier and addend: index = a * b + c
	always_comb begin
		case (rot_q)
			frs_pkg::ROT_90: begin
				op_a = col_q;
				op_b = eff_h;
				op_c = h_m1_r;
			end
			frs_pkg::ROT_180: begin
				op_a = h_m1_r;
				op_b = eff_w;
				op_c = w_m1_c;
			end
			frs_pkg::ROT_270: begin
				op_a = w_m1_c;
				op_b = eff_h;
				op_c = row_q;
			end
			default: begin
				op_a = row_q;
				op_b = eff_w;
				op_c = col_q;
			end
		endcase
	end

	// Hold configuration; any write to width, height or rotation restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= frs_pkg::CFG_DATA_W'(1);
			height_q <= frs_pkg::CFG_DATA_W'(1);
			rot_q    <= frs_pkg::ROT_0;
			row_q    <= '0;
			col_q    <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				frs_pkg::REG_WIDTH:    width_q  <= cfg_data;
				frs_pkg::REG_HEIGHT:   height_q <= cfg_data;
				frs_pkg::REG_ROTATION: rot_q    <= cfg_data[frs_pkg::ROT_W-1:0];
				default: ;
			endcase
			if (cfg_index == frs_pkg::REG_WIDTH || cfg_index == frs_pkg::REG_HEIGHT ||
			    cfg_index == frs_pkg::REG_ROTATION) begin
				row_q <= '0;
				col_q <= '0;
			end
		end else if (push) begin
			// Advance raster position, wrap at row and frame end
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

endmodule

### rtl/frs_queue.sv
// Two-entry queue between the front end and the index back end.
module frs_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = entry_q[rd_ptr_q];

	// Store incoming entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### rtl/frs_back.sv
// Back end: multiply-add of the destination index into the output register.
module frs_back #(
	parameter int MAX_DIM = frs_pkg::MAX_DIM,
	localparam int CNT_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1,
	localparam int DIM_W = $clog2(MAX_DIM + 1),
	localparam int RAW_W = CNT_W + DIM_W + 1,
	localparam int SUM_W = (RAW_W > frs_pkg::IDX_W) ? RAW_W : frs_pkg::IDX_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [CNT_W-1:0]            op_a,
	input  logic [DIM_W-1:0]            op_b,
	input  logic [CNT_W-1:0]            op_c,
	input  logic                        op_last,
	input  logic [frs_pkg::PIXEL_W-1:0] op_pixel,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [frs_pkg::IDX_W-1:0]   dest_index,
	output logic [frs_pkg::PIXEL_W-1:0] pixel_out,
	output logic                        frame_done
);

	logic             valid_q;
	logic             take;
	logic [SUM_W-1:0] sum;

	assign item_ready = ~valid_q | out_ready;
	assign take       = item_valid & item_ready;
	assign out_valid  = valid_q;
	assign sum        = SUM_W'(op_a) * SUM_W'(op_b) + SUM_W'(op_c);

	// Load result when the output register is free or drained this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (item_ready) begin
			valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			dest_index <= sum[frs_pkg::IDX_W-1:0];
			pixel_out  <= op_pixel;
			frame_done <= op_last;
		end
	end

endmodule
